@@ rtl/rpn_pkg.sv @@
// Shared constants, token and status codes, and the divider handshake types
// for the reverse Polish stack evaluator. No dependencies.
package rpn_pkg;

  // Field widths of the input and result items.
  localparam int OP_W    = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 8;

  // Default number of stack entries.
  localparam int STACK_DEPTH_DEF = 128;

  // Q16.16 fraction bits and saturation limits.
  localparam int FRAC_W = 16;
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Token kinds.
  localparam logic [OP_W-1:0] OP_NUM     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB     = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL     = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV     = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD     = 3'd5;
  localparam logic [OP_W-1:0] OP_PRINT   = 3'd6;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZDIV    = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

  // Request to the iterative divider: start pulse, remainder select, operands.
  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } div_req_t;

  // Divider answer: one-cycle done pulse with the saturated Q16.16 value.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } div_rsp_t;

endpackage

@@ rtl/rpn_if.sv @@
// Valid/ready channel interfaces for the token input and the result output.
// Depends on rpn_pkg for the field widths.
interface rpn_in_if;
  logic                             valid;
  logic                             ready;
  logic [rpn_pkg::OP_W-1:0]         op;
  logic signed [rpn_pkg::DATA_W-1:0] operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink   (input valid, input op, input operand, output ready);
endinterface

interface rpn_out_if;
  logic                              valid;
  logic                              ready;
  logic [rpn_pkg::STAT_W-1:0]        status;
  logic signed [rpn_pkg::DATA_W-1:0] result_value;
  logic                              result_valid;
  logic [rpn_pkg::DEPTH_W-1:0]       stack_depth;

  modport source (output valid, output status, output result_value,
                  output result_valid, output stack_depth, input ready);
  modport sink   (input valid, input status, input result_value,
                  input result_valid, input stack_depth, output ready);
endinterface

@@ rtl/rpn_stack_mem.sv @@
// Operand stack storage: one write port and two registered read ports.
// Standalone; no package dependency.
module rpn_stack_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/rpn_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle, for Q16.16 divide
// (saturated) and remainder (sign of the dividend). Depends on rpn_pkg.
module rpn_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);
  import rpn_pkg::*;

  localparam int DVD_W    = DATA_W + FRAC_W;
  localparam int CNT_W    = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(DATA_W - 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] bmag_r, bmag_nxt;
  logic              negq_r, negq_nxt;
  logic              nega_r, nega_nxt;
  logic              mod_r, mod_nxt;

  logic [DATA_W-1:0] amag;
  logic [DATA_W-1:0] bmag;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] q_val;
  logic [DATA_W-1:0] r_val;

  // Operand magnitudes; the most negative value maps to 2^31 exactly.
  assign amag = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
  assign bmag = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, bmag_r};
  assign ge     = ~diff[DATA_W];

  // Quotient with sign and saturation to the Q16.16 range.
  always_comb begin
    if (!negq_r) begin
      q_val = (dvd_r[DVD_W-1:DATA_W-1] != '0) ? Q_MAX : dvd_r[DATA_W-1:0];
    end else if (dvd_r > DVD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
      q_val = Q_MIN;
    end else begin
      q_val = ~dvd_r[DATA_W-1:0] + 1'b1;
    end
  end

  // Remainder takes the sign of the dividend and always fits.
  assign r_val = nega_r ? (~rem_r + 1'b1) : rem_r;

  assign rsp.done  = (state_r == D_FIN);
  assign rsp.value = mod_r ? r_val : q_val;

  // Sequencer for the iterations.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    bmag_nxt  = bmag_r;
    negq_nxt  = negq_r;
    nega_nxt  = nega_r;
    mod_nxt   = mod_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          // Both operations scan the dividend |a| * 2^16 from the top; the
          // remainder only needs the integer part.
          dvd_nxt   = {amag, {FRAC_W{1'b0}}};
          rem_nxt   = '0;
          bmag_nxt  = bmag;
          negq_nxt  = req.a[DATA_W-1] ^ req.b[DATA_W-1];
          nega_nxt  = req.a[DATA_W-1];
          mod_nxt   = req.is_mod;
          cnt_nxt   = req.is_mod ? MOD_LAST : DIV_LAST;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    bmag_r <= bmag_nxt;
    negq_r <= negq_nxt;
    nega_r <= nega_nxt;
    mod_r  <= mod_nxt;
  end

  // A new request only arrives while the divider is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == D_IDLE)
    else $error("divider started while busy");

  // Every finished run is followed by a return to idle.
  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_FIN |=> state_r == D_IDLE)
    else $error("divider done held longer than one cycle");

  // A run never begins without a start request.
  a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_IDLE && !req.start |=> state_r == D_IDLE)
    else $error("divider left idle without a request");

endmodule

@@ rtl/rpn_stack_evaluator.sv @@
// Top level of the reverse Polish evaluator: control sequencer, add/sub/mul
// datapath and output register. Depends on rpn_pkg, rpn_if, rpn_stack_mem and
// rpn_divider.
//
// Usage: tokens arrive on in_ch (op, operand) with valid/ready; one result item
// per token leaves on out_ch (status, result_value, result_valid, stack_depth).
// The operand stack lives in a memory with registered reads; the top two
// entries are read when a token is accepted and the new top is written back
// when its result item is loaded into the output register.
// An accepted token is evaluated in S_READ and its result item is loaded in
// S_OUT; multiply passes through S_MUL, while divide and remainder wait in
// S_DIV for the divider, which retires one quotient bit per cycle (48 steps
// for divide, 32 for remainder). One token is in flight at a time, and the
// next is accepted the cycle after the previous result is loaded.
// Reset (rst_n low at a clock edge) empties the stack, clears the halt flag
// and drops any pending result; stack contents are not cleared.
// When out_ch stalls, the finished item waits in the output register and the
// following token is still taken and worked on up to its write-back, which
// waits for the output register to free.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rpn_in_if.sink     in_ch,
  rpn_out_if.source  out_ch
);
  import rpn_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic                   halted_r, halted_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [DATA_W-1:0]      operand_r, operand_nxt;
  logic signed [63:0]     prod_r, prod_nxt;

  // Pending commit of the token being worked on.
  logic [STAT_W-1:0]      pst_r, pst_nxt;
  logic [DATA_W-1:0]      pval_r, pval_nxt;
  logic                   pvalid_r, pvalid_nxt;
  logic [SPW-1:0]         psp_r, psp_nxt;
  logic                   phalt_r, phalt_nxt;
  logic                   pwe_r, pwe_nxt;
  logic [AW-1:0]          pwaddr_r, pwaddr_nxt;
  logic [DATA_W-1:0]      pwdata_r, pwdata_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [DATA_W-1:0]      out_value_r, out_value_nxt;
  logic                   out_rvalid_r, out_rvalid_nxt;
  logic [DEPTH_W-1:0]     out_depth_r, out_depth_nxt;

  logic                   out_free;
  logic [AW-1:0]          top_addr;
  logic [AW-1:0]          next_addr;
  logic [DATA_W-1:0]      rd_top;
  logic [DATA_W-1:0]      rd_next;
  logic                   mem_we;
  logic signed [63:0]     prod_sh;
  logic [DATA_W-1:0]      mul_sat;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Saturate a 33-bit signed sum to Q16.16.
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // Stack memory; reads follow the current stack pointer.
  assign top_addr  = (sp_r >= SPW'(1)) ? AW'(sp_r - SPW'(1)) : '0;
  assign next_addr = (sp_r >= SPW'(2)) ? AW'(sp_r - SPW'(2)) : '0;
  assign mem_we    = (state_r == S_OUT) && out_free && pwe_r;

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (pwaddr_r),
    .wdata   (pwdata_r),
    .raddr_a (top_addr),
    .raddr_b (next_addr),
    .rdata_a (rd_top),
    .rdata_b (rd_next)
  );

  rpn_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Product floor-shifted to Q16.16 and saturated.
  assign prod_sh = prod_r >>> FRAC_W;
  always_comb begin
    if ((prod_sh[63:DATA_W-1] == '0) || (prod_sh[63:DATA_W-1] == '1)) begin
      mul_sat = prod_sh[DATA_W-1:0];
    end else begin
      mul_sat = prod_sh[63] ? Q_MIN : Q_MAX;
    end
  end

  // Handshakes and output payload.
  assign out_free            = !out_valid_r || out_ch.ready;
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.result_valid = out_rvalid_r;
  assign out_ch.stack_depth  = out_depth_r;

  // Control sequencer: read, evaluate, optional multiply or divide, commit.
  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    halted_nxt     = halted_r;
    op_nxt         = op_r;
    operand_nxt    = operand_r;
    prod_nxt       = prod_r;
    pst_nxt        = pst_r;
    pval_nxt       = pval_r;
    pvalid_nxt     = pvalid_r;
    psp_nxt        = psp_r;
    phalt_nxt      = phalt_r;
    pwe_nxt        = pwe_r;
    pwaddr_nxt     = pwaddr_r;
    pwdata_nxt     = pwdata_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_rvalid_nxt = out_rvalid_r;
    out_depth_nxt  = out_depth_r;
    div_req        = '0;
    div_req.a      = rd_next;
    div_req.b      = rd_top;
    div_req.is_mod = (op_r == OP_MOD);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.op;
          operand_nxt = in_ch.operand;
          state_nxt   = S_READ;
        end
      end

      S_READ: begin
        // Top two entries are now in rd_top and rd_next.
        pst_nxt    = ST_OK;
        pval_nxt   = '0;
        pvalid_nxt = 1'b0;
        psp_nxt    = sp_r;
        phalt_nxt  = halted_r;
        pwe_nxt    = 1'b0;
        pwaddr_nxt = AW'(sp_r - SPW'(2));
        pwdata_nxt = operand_r;
        state_nxt  = S_OUT;
        if (halted_r) begin
          pst_nxt = ST_UNDER;
        end else if (op_r == OP_NUM) begin
          if (sp_r < SPW'(STACK_DEPTH)) begin
            pwe_nxt    = 1'b1;
            pwaddr_nxt = AW'(sp_r);
            psp_nxt    = sp_r + SPW'(1);
          end else begin
            pst_nxt = ST_FULL;
          end
        end else if (op_r == OP_PRINT) begin
          if (sp_r == '0) begin
            pst_nxt   = ST_UNDER;
            phalt_nxt = 1'b1;
          end else begin
            pval_nxt   = rd_top;
            pvalid_nxt = 1'b1;
            psp_nxt    = sp_r - SPW'(1);
          end
        end else if (op_r == OP_UNKNOWN) begin
          pst_nxt = ST_UNKNOWN;
        end else if ((op_r == OP_DIV || op_r == OP_MOD) && sp_r >= SPW'(1) &&
                     rd_top == '0) begin
          // Zero divisor: drop it and keep the dividend.
          pst_nxt = ST_ZDIV;
          psp_nxt = sp_r - SPW'(1);
        end else if (sp_r < SPW'(2)) begin
          pst_nxt   = ST_UNDER;
          phalt_nxt = 1'b1;
        end else begin
          // Binary operation: two pops, one push of the result.
          pwe_nxt = 1'b1;
          psp_nxt = sp_r - SPW'(1);
          case (op_r) inside
            OP_ADD: begin
              pwdata_nxt = sat33({rd_next[DATA_W-1], rd_next} +
                                 {rd_top[DATA_W-1], rd_top});
            end
            OP_SUB: begin
              pwdata_nxt = sat33({rd_next[DATA_W-1], rd_next} -
                                 {rd_top[DATA_W-1], rd_top});
            end
            OP_MUL: begin
              prod_nxt  = $signed(rd_next) * $signed(rd_top);
              state_nxt = S_MUL;
            end
            OP_DIV, OP_MOD: begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
            default: begin
              pwe_nxt = 1'b0;
            end
          endcase
        end
      end

      S_MUL: begin
        pwdata_nxt = mul_sat;
        state_nxt  = S_OUT;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          pwdata_nxt = div_rsp.value;
          state_nxt  = S_OUT;
        end
      end

      S_OUT: begin
        // Commit stack state together with loading the result item.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pst_r;
          out_value_nxt  = pval_r;
          out_rvalid_nxt = pvalid_r;
          out_depth_nxt  = DEPTH_W'(psp_r);
          sp_nxt         = psp_r;
          halted_nxt     = phalt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    operand_r    <= operand_nxt;
    prod_r       <= prod_nxt;
    pst_r        <= pst_nxt;
    pval_r       <= pval_nxt;
    pvalid_r     <= pvalid_nxt;
    psp_r        <= psp_nxt;
    phalt_r      <= phalt_nxt;
    pwe_r        <= pwe_nxt;
    pwaddr_r     <= pwaddr_nxt;
    pwdata_r     <= pwdata_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  // The stack pointer never passes the stack size.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack size");

  // Once halted, only reset clears the flag.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // A printed value only comes with an ok status.
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rvalid_r |-> out_status_r == ST_OK)
    else $error("printed value with error status");

  // While halted, every delivered item reports underflow.
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && halted_r |-> out_status_r == ST_UNDER)
    else $error("halted evaluator produced a non-underflow status");

endmodule

@@ test/rpn_stack_evaluator_tb.sv @@
// Self-checking testbench for rpn_stack_evaluator: drives lexed tokens, predicts every
// result item with its own Q16.16 stack model and compares each one field by field.
// Depends on rpn_pkg, the channel interfaces in rpn_if and the evaluator RTL.
`timescale 1ns / 1ps

module rpn_stack_evaluator_tb;
  import rpn_pkg::*;

  localparam int          STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          MAX_REPORTS  = 10;

  // One predicted result item.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  value;
    logic               printed;
    logic [DEPTH_W-1:0] depth;
  } token_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rpn_in_if  in_if ();
  rpn_out_if out_if ();

  rpn_stack_evaluator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the evaluator state.
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int                model_sp = 0;
  bit                model_halted = 1'b0;

  token_result_t pending_results [$];
  int unsigned   result_errors = 0;
  int unsigned   cycle_count = 0;

  // Idle controls for the two sides, changed between test phases.
  bit in_gaps = 1'b1;
  bit out_stalls = 1'b1;

  // Clamp a wide value to the signed Q16.16 range.
  function automatic logic [DATA_W-1:0] clamp_q(input longint v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return Q_MAX;
    if (v < 64'shFFFF_FFFF_8000_0000) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Apply one token to the shadow stack and return the result item it must produce.
  function automatic token_result_t evaluate_token(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] operand);
    token_result_t     res;
    longint            lhs;
    longint            rhs;
    logic [DATA_W-1:0] top;
    res = '0;
    res.status = ST_OK;
    if (model_halted) begin
      res.status = ST_UNDER;
    end else if (op == OP_NUM) begin
      if (model_sp < STACK_DEPTH) begin
        model_stack[model_sp] = operand;
        model_sp++;
      end else begin
        res.status = ST_FULL;
      end
    end else if (op == OP_PRINT) begin
      if (model_sp == 0) begin
        res.status = ST_UNDER;
        model_halted = 1'b1;
      end else begin
        model_sp--;
        res.value = model_stack[model_sp];
        res.printed = 1'b1;
      end
    end else if (op == OP_UNKNOWN) begin
      res.status = ST_UNKNOWN;
    end else if ((op == OP_DIV || op == OP_MOD) && model_sp >= 1 &&
                 model_stack[model_sp-1] == '0) begin
      // A zero divisor is dropped and the dividend stays.
      model_sp--;
      res.status = ST_ZDIV;
    end else if (model_sp < 2) begin
      res.status = ST_UNDER;
      model_halted = 1'b1;
    end else begin
      rhs = longint'(signed'(model_stack[model_sp-1]));
      lhs = longint'(signed'(model_stack[model_sp-2]));
      case (op)
        OP_ADD:  top = clamp_q(lhs + rhs);
        OP_SUB:  top = clamp_q(lhs - rhs);
        OP_MUL:  top = clamp_q((lhs * rhs) >>> FRAC_W);
        OP_DIV:  top = clamp_q((lhs * 64'sd65536) / rhs);
        default: top = clamp_q(lhs % rhs);
      endcase
      model_sp--;
      model_stack[model_sp-1] = top;
    end
    res.depth = DEPTH_W'(model_sp);
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] op_code(input int idx);
    case (idx)
      0:       return OP_NUM;
      1:       return OP_ADD;
      2:       return OP_SUB;
      3:       return OP_MUL;
      4:       return OP_DIV;
      5:       return OP_MOD;
      6:       return OP_PRINT;
      default: return OP_UNKNOWN;
    endcase
  endfunction

  // Operand mix: zeros, range edges, small numbers and full random words.
  function automatic logic [DATA_W-1:0] random_q16();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return '0;
    if (pick < 4) begin
      case ($urandom_range(0, 5))
        0:       return Q_MAX;
        1:       return Q_MIN;
        2:       return 32'h0000_0001;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    if (pick < 8) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    return $urandom();
  endfunction

  // Pick a token that keeps the stack out of underflow, so the halt stays unset.
  function automatic logic [OP_W-1:0] pick_op(input int push_pct);
    logic [OP_W-1:0] op;
    bit              zero_top;
    if ($urandom_range(0, 99) < push_pct) return OP_NUM;
    op = op_code($urandom_range(1, 7));
    zero_top = model_sp >= 1 && model_stack[model_sp-1] == '0;
    if (op == OP_PRINT && model_sp == 0) return OP_NUM;
    if (op != OP_PRINT && op != OP_UNKNOWN && model_sp < 2 &&
        !((op == OP_DIV || op == OP_MOD) && zero_top))
      return OP_NUM;
    return op;
  endfunction

  // Offer one item on the token channel and wait until it is taken.
  task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand);
    int gap;
    gap = in_gaps ? idle_cycles() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.operand <= operand;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(evaluate_token(op, operand));
  endtask

  // Push two operands, apply the operation and print its result.
  task automatic run_binary(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] lhs,
                            input logic [DATA_W-1:0] rhs);
    send_token(OP_NUM, lhs);
    send_token(OP_NUM, rhs);
    send_token(op, $urandom());
    send_token(OP_PRINT, $urandom());
  endtask

  task automatic test_push_print();
    send_token(OP_NUM, Q_MAX);
    send_token(OP_NUM, Q_MIN);
    send_token(OP_NUM, '0);
    repeat (3) send_token(OP_PRINT, $urandom());
  endtask

  // Saturation at both ends, the sign of a remainder and divide overflow.
  task automatic test_arith_limits();
    run_binary(OP_ADD, Q_MAX, 32'h0000_0001);
    run_binary(OP_SUB, Q_MIN, 32'h0000_0001);
    run_binary(OP_MUL, Q_MIN, Q_MIN);
    run_binary(OP_DIV, Q_MIN, 32'hFFFF_FFFF);
    run_binary(OP_MOD, 32'hFFF9_0000, 32'h0002_0000);
  endtask

  task automatic test_zero_divisor();
    send_token(OP_NUM, 32'h0005_0000);
    send_token(OP_NUM, '0);
    send_token(OP_DIV, $urandom());
    send_token(OP_NUM, '0);
    send_token(OP_MOD, $urandom());
    send_token(OP_PRINT, $urandom());
    // A lone zero on the stack is still a zero divisor, not an underflow.
    send_token(OP_NUM, '0);
    send_token(OP_DIV, $urandom());
  endtask

  task automatic test_unknown_token();
    send_token(OP_NUM, 32'h0000_0001);
    send_token(OP_UNKNOWN, $urandom());
    send_token(OP_PRINT, $urandom());
  endtask

  task automatic test_random_mix(input int count, input int push_pct);
    int k;
    for (k = 0; k < count; k++) send_token(pick_op(push_pct), random_q16());
  endtask

  // The halt is sticky until reset, so this runs last.
  task automatic test_underflow_halt();
    int k;
    while (model_sp > 0) send_token(OP_PRINT, $urandom());
    send_token(OP_NUM, 32'h0003_0000);
    send_token(OP_SUB, $urandom());
    for (k = 0; k < 24; k++) send_token(op_code(k % 8), random_q16());
  endtask

  // Result side ready with random stalls.
  initial begin
    int hold;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = out_stalls ? idle_cycles() : 0;
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    token_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        result_errors++;
        if (result_errors <= MAX_REPORTS)
          $display("cycle %0d: unexpected result item, status %0d value %h depth %0d",
                   cycle_count, out_if.status, out_if.result_value, out_if.stack_depth);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status || out_if.result_value !== want.value ||
            out_if.result_valid !== want.printed || out_if.stack_depth !== want.depth) begin
          result_errors++;
          if (result_errors <= MAX_REPORTS) begin
            $display("cycle %0d: expected status %0d value %h valid %b depth %0d",
                     cycle_count, want.status, want.value, want.printed, want.depth);
            $display("cycle %0d:      got status %0d value %h valid %b depth %0d",
                     cycle_count, out_if.status, out_if.result_value,
                     out_if.result_valid, out_if.stack_depth);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.op      <= OP_NUM;
    in_if.operand <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_push_print();
    test_arith_limits();
    test_zero_divisor();
    test_unknown_token();

    // Random phases: balanced, filling to full, draining, then varied idling.
    test_random_mix(250, 50);
    test_random_mix(250, 85);
    test_random_mix(200, 25);
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    test_random_mix(200, 55);
    in_gaps = 1'b1;
    test_random_mix(150, 60);
    in_gaps = 1'b0;
    out_stalls = 1'b1;
    test_random_mix(150, 45);
    in_gaps = 1'b1;

    test_underflow_halt();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_errors == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
